[rtl/core/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// TGA run-length decoder package
// Types and constants shared by the decoder, its channel interfaces and its
// checker.
// ----------------------------------------------------------------------------
package tgarle_pkg;

	localparam int BYTE_W   = 8;
	localparam int COLOR_W  = 24;
	localparam int ALPHA_W  = 8;
	localparam int REPEAT_W = 8;
	localparam int RUN_W    = 7;
	localparam int BPP_W    = 2;
	localparam int IDX_W    = 2;
	localparam int ACC_W    = 32;
	localparam int COUNT_W  = 32;
	localparam int APB_W    = 32;
	localparam int PADDR_W  = 4;

	// Bit of the packet header that marks a repeat packet.
	localparam int HDR_REPEAT_BIT = 7;

	// Largest run a single packet can carry.
	localparam logic [REPEAT_W-1:0] MAX_RUN = 8'd128;

	// Packet parser phase, one-hot.
	typedef enum logic [1:0] {
		PH_HEADER = 2'b01,
		PH_PIXEL  = 2'b10
	} phase_t;

	// Configuration register index (byte address divided by four).
	typedef enum logic [1:0] {
		REG_BPP   = 2'd0,
		REG_ALPHA = 2'd1,
		REG_COUNT = 2'd2
	} reg_idx_t;

endpackage

[rtl/core/tgarle_if.sv]
// ----------------------------------------------------------------------------
// TGA run-length decoder channels
// Valid/ready interfaces for the coded byte stream and the pixel results.
// ----------------------------------------------------------------------------
interface tgarle_in_if
	import tgarle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tgarle_out_if
	import tgarle_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [COLOR_W-1:0]  color;
	logic [ALPHA_W-1:0]  alpha_value;
	logic [REPEAT_W-1:0] repeat_res;
	logic                image_done;
	logic                overrun;

	modport source (output valid, output color, output alpha_value, output repeat_res,
		output image_done, output overrun, input ready);
	modport sink   (input valid, input color, input alpha_value, input repeat_res,
		input image_done, input overrun, output ready);
endinterface

[rtl/core/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder
// Parses the run-length coded pixel stream of a TGA image one byte per beat
// and emits one result beat per decoded pixel or run.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                    handshake
//  --------  ---------  -----------------------------------------  -----------
//  byte_in   sink       stream_byte[7:0]                           valid/ready
//  pix_out   source     color, alpha_value, repeat_res,            valid/ready
//                       image_done, overrun
//  apb       slave      paddr[3:0], pwdata/prdata[31:0]            psel/penable
//
//  One coded byte is taken every clock while the result register is free:
//  the parser state and the result register are both updated at the edge
//  that accepts the byte, so a result appears in the cycle after the
//  pixel's last byte. The single result register sets the limit: a byte
//  is taken whenever that register is empty or is being emptied in the same
//  cycle. Reset (arst_n low) restores the register defaults and leaves the
//  parser awaiting a packet header. Writes to APB take effect immediately;
//  writing the pixel count restarts the image.
//
module tga_rle_pixel_decoder
	import tgarle_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tgarle_in_if.sink          byte_in,
	tgarle_out_if.source       pix_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready
);

	// Configuration registers.
	logic [BPP_W-1:0]   bpp_q;
	logic               has_alpha_q;
	logic [COUNT_W-1:0] pixel_count_q;

	// Parser state.
	phase_t             phase_q, phase_n;
	logic [RUN_W-1:0]   packet_left_q, packet_left_n;
	logic               is_repeat_q, is_repeat_n;
	logic [IDX_W-1:0]   byte_idx_q, byte_idx_n;
	logic [ACC_W-1:0]   acc_q, acc_n;
	logic [COUNT_W-1:0] pixels_left_q, pixels_left_n;

	// Result register.
	logic                out_valid_q;
	logic [COLOR_W-1:0]  color_q, color_n;
	logic [ALPHA_W-1:0]  alpha_q, alpha_n;
	logic [REPEAT_W-1:0] repeat_q, repeat_n;
	logic                done_q, done_n;
	logic                overrun_q, overrun_n;
	logic                emit;

	// Handshakes and helpers.
	logic               in_fire, out_fire, cfg_wr;
	reg_idx_t           reg_idx;
	logic [BYTE_W-1:0]  b;
	logic [BPP_W-1:0]   bpp_eff;
	logic [2:0]         total;
	logic [2:0]         idx_inc;
	logic [ACC_W-1:0]   acc_merged;
	logic [REPEAT_W-1:0] run;
	logic               run_reaches_end;
	logic [COUNT_W-1:0] count_eff;
	logic [COUNT_W-1:0] wr_count_eff;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_idx  = reg_idx_t'(paddr[PADDR_W-1:2]);

	// A new byte may enter whenever the result register is free this cycle.
	assign byte_in.ready = !out_valid_q || pix_out.ready;
	assign in_fire       = byte_in.valid && byte_in.ready;
	assign out_fire      = out_valid_q && pix_out.ready;

	assign b            = byte_in.stream_byte;
	assign bpp_eff      = (bpp_q == '0) ? BPP_W'(1) : bpp_q;
	assign total        = {1'b0, bpp_eff} + {2'b00, has_alpha_q};
	assign idx_inc      = {1'b0, byte_idx_q} + 3'd1;
	assign acc_merged   = acc_q | ({{(ACC_W-BYTE_W){1'b0}}, b} << {byte_idx_q, 3'b000});
	assign run          = {1'b0, packet_left_q} + REPEAT_W'(1);
	assign run_reaches_end = {{(COUNT_W-REPEAT_W){1'b0}}, run} >= pixels_left_q;
	assign count_eff    = (pixel_count_q == '0) ? COUNT_W'(1) : pixel_count_q;
	assign wr_count_eff = (pwdata == '0) ? COUNT_W'(1) : pwdata;

	// Register read-back.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_BPP:   prdata = {{(APB_W-BPP_W){1'b0}}, bpp_q};
			REG_ALPHA: prdata = {{(APB_W-1){1'b0}}, has_alpha_q};
			REG_COUNT: prdata = pixel_count_q;
			default:   prdata = '0;
		endcase
	end

	// Colour and alpha are picked from the merged accumulator by pixel size.
	always_comb begin
		case (bpp_eff)
			2'd1: begin
				color_n = {16'h0000, acc_merged[7:0]};
				alpha_n = acc_merged[15:8];
			end
			2'd2: begin
				color_n = {8'h00, acc_merged[15:0]};
				alpha_n = acc_merged[23:16];
			end
			default: begin
				color_n = acc_merged[23:0];
				alpha_n = acc_merged[31:24];
			end
		endcase
		if (!has_alpha_q) begin
			alpha_n = '0;
		end
	end

	// Parser next state and result for the byte on the input.
	always_comb begin
		phase_n       = phase_q;
		packet_left_n = packet_left_q;
		is_repeat_n   = is_repeat_q;
		byte_idx_n    = byte_idx_q;
		acc_n         = acc_q;
		pixels_left_n = pixels_left_q;
		emit          = 1'b0;
		repeat_n      = REPEAT_W'(1);
		done_n        = 1'b0;
		overrun_n     = 1'b0;

		if (in_fire) begin
			unique case (phase_q)
				PH_HEADER: begin
					is_repeat_n   = b[HDR_REPEAT_BIT];
					packet_left_n = b[RUN_W-1:0];
					byte_idx_n    = '0;
					acc_n         = '0;
					phase_n       = PH_PIXEL;
				end
				PH_PIXEL: begin
					if (idx_inc < total) begin
						byte_idx_n = idx_inc[IDX_W-1:0];
						acc_n      = acc_merged;
					end else begin
						emit       = 1'b1;
						byte_idx_n = '0;
						acc_n      = '0;
						if (is_repeat_q) begin
							phase_n = PH_HEADER;
							if (run_reaches_end) begin
								// The run meets or passes the image end: cut it.
								repeat_n  = pixels_left_q[REPEAT_W-1:0];
								overrun_n = ({{(COUNT_W-REPEAT_W){1'b0}}, run} != pixels_left_q);
								done_n    = 1'b1;
							end else begin
								repeat_n      = run;
								pixels_left_n = pixels_left_q - {{(COUNT_W-REPEAT_W){1'b0}}, run};
							end
						end else begin
							if (pixels_left_q == COUNT_W'(1)) begin
								done_n    = 1'b1;
								overrun_n = (packet_left_q != '0);
							end else if (packet_left_q == '0) begin
								phase_n       = PH_HEADER;
								pixels_left_n = pixels_left_q - COUNT_W'(1);
							end else begin
								packet_left_n = packet_left_q - RUN_W'(1);
								pixels_left_n = pixels_left_q - COUNT_W'(1);
							end
						end
						if (done_n) begin
							// Last pixel of the image: start over on a new header.
							phase_n       = PH_HEADER;
							packet_left_n = '0;
							is_repeat_n   = 1'b0;
							pixels_left_n = count_eff;
						end
					end
				end
				default: begin
					phase_n = PH_HEADER;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= BPP_W'(3);
			has_alpha_q   <= 1'b0;
			pixel_count_q <= COUNT_W'(1);
			phase_q       <= PH_HEADER;
			packet_left_q <= '0;
			is_repeat_q   <= 1'b0;
			byte_idx_q    <= '0;
			acc_q         <= '0;
			pixels_left_q <= COUNT_W'(1);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr && (reg_idx == REG_COUNT)) begin
				// A new image size drops any partial packet.
				phase_q       <= PH_HEADER;
				packet_left_q <= '0;
				is_repeat_q   <= 1'b0;
				byte_idx_q    <= '0;
				acc_q         <= '0;
				pixels_left_q <= wr_count_eff;
			end else begin
				phase_q       <= phase_n;
				packet_left_q <= packet_left_n;
				is_repeat_q   <= is_repeat_n;
				byte_idx_q    <= byte_idx_n;
				acc_q         <= acc_n;
				pixels_left_q <= pixels_left_n;
			end

			if (cfg_wr) begin
				unique case (reg_idx)
					REG_BPP:   bpp_q         <= pwdata[BPP_W-1:0];
					REG_ALPHA: has_alpha_q   <= pwdata[0];
					REG_COUNT: pixel_count_q <= pwdata;
					default: ;
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded alongside the valid flag.
	always_ff @(posedge clk) begin
		if (emit) begin
			color_q   <= color_n;
			alpha_q   <= alpha_n;
			repeat_q  <= repeat_n;
			done_q    <= done_n;
			overrun_q <= overrun_n;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.color       = color_q;
	assign pix_out.alpha_value = alpha_q;
	assign pix_out.repeat_res  = repeat_q;
	assign pix_out.image_done  = done_q;
	assign pix_out.overrun     = overrun_q;

endmodule

[rtl/core/tgarle_checker.sv]
// ----------------------------------------------------------------------------
// TGA run-length decoder checker
// Port-level assertions on the decoder, attached to it by a bind.
// ----------------------------------------------------------------------------
module tgarle_checker
	import tgarle_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [REPEAT_W-1:0] repeat_res,
	input logic                image_done,
	input logic                overrun
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	// With the result register empty the decoder always takes a byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

	// A truncated run is always the image's last one.
	a_overrun_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> image_done)
		else $error("overrun without image end");

	// Run lengths stay between one and the packet maximum.
	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (repeat_res != '0) && (repeat_res <= MAX_RUN))
		else $error("run length out of range");

	// A new result only follows an accepted byte.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && (!out_valid || out_ready) |=> !out_valid)
		else $error("result without an input byte");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_in.valid),
	.in_ready   (byte_in.ready),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.repeat_res (pix_out.repeat_res),
	.image_done (pix_out.image_done),
	.overrun    (pix_out.overrun)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder testbench
// Feeds coded TGA pixel streams to the decoder under randomly varied register
// settings and idling on both channels, and checks every pixel beat against
// an in-bench decoder of the same stream.
// ----------------------------------------------------------------------------
module tb;
	import tgarle_pkg::*;

	// Random coded bytes to send after the directed part.
	localparam int RANDOM_BYTES = 1700;
	// Cycles allowed for the last byte to work through the decoder.
	localparam int DRAIN_CYCLES = 4;
	localparam int END_CYCLES   = 8;
	// Cycles with no beat on either channel before the run is abandoned.
	// The longest quiet stretch in a correct run is a register change plus
	// a full gap and stall.
	localparam int STALL_LIMIT  = 400;
	localparam int MAX_REPORTS  = 10;

	// One pixel result beat, laid out field by field.
	typedef struct packed {
		logic [COLOR_W-1:0]  color;
		logic [ALPHA_W-1:0]  alpha_value;
		logic [REPEAT_W-1:0] repeat_res;
		logic                image_done;
		logic                overrun;
	} pixel_beat_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0]   pwdata;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	tgarle_in_if  byte_if ();
	tgarle_out_if pix_if ();

	tga_rle_pixel_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_if),
		.pix_out (pix_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Coded bytes waiting to be sent, and the pixel beats the stream so far
	// must produce, oldest first.
	logic [BYTE_W-1:0] coded_bytes[$];
	pixel_beat_t       decoded_runs[$];

	// Register copies as the decoder should hold them.
	logic [BPP_W-1:0]   cfg_bpp;
	logic               cfg_alpha;
	logic [COUNT_W-1:0] cfg_count;

	// Packet parser state of the in-bench decoder.
	phase_t             dec_phase;
	logic [RUN_W-1:0]   dec_left;
	logic               dec_is_repeat;
	logic [IDX_W-1:0]   dec_idx;
	logic [ACC_W-1:0]   dec_acc;
	logic [COUNT_W-1:0] dec_pixels_left;

	// Handshake flags of the last rising edge, read by the drivers at the
	// following falling edge.
	bit byte_taken;
	bit beat_taken;

	// Idling controls, changed from one register setting to the next.
	bit in_idling;
	bit out_idling;
	int unsigned send_gap;
	int unsigned hold_off;

	int unsigned bytes_queued;
	int unsigned bytes_taken;
	int unsigned beats_checked;
	int unsigned images_seen;
	int unsigned overruns_seen;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned settings_run;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// In-bench decoder
	// ------------------------------------------------------------------

	// A new image starts: the parser waits for a header and the pixel
	// budget reloads, with a zero count standing for a single pixel.
	function automatic void restart_image();
		dec_phase       = PH_HEADER;
		dec_left        = '0;
		dec_is_repeat   = 1'b0;
		dec_idx         = '0;
		dec_acc         = '0;
		dec_pixels_left = (cfg_count == '0) ? COUNT_W'(1) : cfg_count;
	endfunction

	// Takes one coded byte and queues the pixel beat it completes, if any.
	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		int unsigned        bpp;
		int unsigned        px_len;
		logic [COUNT_W-1:0] run;
		logic [ACC_W-1:0]   mask;
		pixel_beat_t        beat;

		if (dec_phase != PH_PIXEL) begin
			dec_is_repeat = b[HDR_REPEAT_BIT];
			dec_left      = b[RUN_W-1:0];
			dec_idx       = '0;
			dec_acc       = '0;
			dec_phase     = PH_PIXEL;
			return;
		end

		// A zero pixel width behaves as one byte. The length is taken from
		// the registers as they stand now, so a pixel whose width shrank
		// part way through ends at the first byte that reaches it.
		bpp     = (cfg_bpp == '0) ? 1 : cfg_bpp;
		px_len  = bpp + cfg_alpha;
		dec_acc = dec_acc | (ACC_W'(b) << (8 * dec_idx));
		if (dec_idx + 1 < px_len) begin
			dec_idx = dec_idx + 1'b1;
			return;
		end

		mask             = (ACC_W'(1) << (8 * bpp)) - 1;
		beat.color       = COLOR_W'(dec_acc & mask);
		beat.alpha_value = cfg_alpha ? ALPHA_W'(dec_acc >> (8 * bpp)) : '0;
		beat.image_done  = 1'b0;
		beat.overrun     = 1'b0;
		dec_idx          = '0;
		dec_acc          = '0;

		if (dec_is_repeat) begin
			// A run that reaches past the image end is cut to the pixels left.
			run       = COUNT_W'(dec_left) + 1;
			dec_phase = PH_HEADER;
			if (run >= dec_pixels_left) begin
				beat.overrun    = (run > dec_pixels_left);
				run             = dec_pixels_left;
				beat.image_done = 1'b1;
				restart_image();
			end else begin
				dec_pixels_left = dec_pixels_left - run;
			end
		end else begin
			// A literal packet stops at the image's last pixel; whatever it
			// still owed is then read as fresh headers.
			run             = 1;
			dec_pixels_left = dec_pixels_left - 1;
			if (dec_pixels_left == '0) begin
				beat.image_done = 1'b1;
				beat.overrun    = (dec_left != '0);
				restart_image();
			end else if (dec_left == '0) begin
				dec_phase = PH_HEADER;
			end else begin
				dec_left = dec_left - 1'b1;
			end
		end
		beat.repeat_res = REPEAT_W'(run);
		decoded_runs.push_back(beat);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_coded(input logic [BYTE_W-1:0] b);
		coded_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Colour and alpha bytes lean towards the extremes now and then.
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	// Register write: a setup phase, then an access phase that completes at
	// the rising edge where pready is seen high. The register copy follows
	// once the write has landed, while the decoder is idle.
	task automatic apb_write(input reg_idx_t idx, input logic [APB_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BPP: cfg_bpp = value[BPP_W-1:0];
			REG_ALPHA: cfg_alpha = value[0];
			REG_COUNT: begin
				// Writing the count drops any partial packet.
				cfg_count = value[COUNT_W-1:0];
				restart_image();
			end
			default: ;
		endcase
	endtask

	// Waits until every queued byte has gone in and every pixel beat owed
	// has come out, then lets a header or partial pixel settle.
	task automatic wait_drained(input int unsigned settle);
		while (bytes_taken != bytes_queued || decoded_runs.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Queues a well-formed image of the given size: packets of random kind
	// and length with random pixel data. The final packet sometimes claims
	// more pixels than remain, which the decoder must cut and flag. Stops
	// early once the byte budget is spent.
	task automatic queue_image(input int unsigned pixels, input int unsigned budget);
		int unsigned covered;
		int unsigned first;
		int unsigned px_len;
		int unsigned run;
		int unsigned n;
		bit          is_rep;

		covered = 0;
		first   = bytes_queued;
		px_len  = ((cfg_bpp == '0) ? 1 : cfg_bpp) + cfg_alpha;
		while (covered < pixels && bytes_queued - first < budget) begin
			is_rep = $urandom_range(0, 1);
			run    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
			                                     : $urandom_range(1, 6);
			if (run > pixels - covered && $urandom_range(0, 3) != 0)
				run = pixels - covered;
			push_coded({is_rep, RUN_W'(run - 1)});
			// A literal packet that overshoots only carries the pixels the
			// image still needs, so the next image starts on a header.
			n = is_rep ? 1 : ((run > pixels - covered) ? pixels - covered : run);
			repeat (n * px_len) push_coded(pick_byte());
			covered += run;
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers: inputs change at the falling edge only
	// ------------------------------------------------------------------

	// Coded byte source. A byte is held until its beat completes; after each
	// beat a gap may follow while in_idling is set.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!byte_if.valid || byte_taken) begin
				if (byte_taken)
					send_gap = in_idling ? $urandom_range(0, 8) : 0;
				if (send_gap != 0) begin
					send_gap--;
					byte_if.valid <= 1'b0;
				end else if (coded_bytes.size() != 0) begin
					byte_if.valid       <= 1'b1;
					byte_if.stream_byte <= coded_bytes.pop_front();
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	// Pixel sink. After each beat it may stall while out_idling is set.
	always @(negedge clk) begin
		if (arst_n) begin
			if (beat_taken)
				hold_off = out_idling ? $urandom_range(0, 8) : 0;
			if (hold_off != 0) begin
				hold_off--;
				pix_if.ready <= 1'b0;
			end else begin
				pix_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor and watchdog: everything is sampled at the rising edge
	// ------------------------------------------------------------------

	// The output beat is checked before the byte of the same edge is
	// decoded; the decoder's result register means a pixel never leaves at
	// the edge that brings its last byte in.
	always @(posedge clk) begin
		pixel_beat_t got;
		pixel_beat_t want;

		beat_taken = arst_n && pix_if.valid && pix_if.ready;
		byte_taken = arst_n && byte_if.valid && byte_if.ready;

		if (beat_taken) begin
			got = '{pix_if.color, pix_if.alpha_value, pix_if.repeat_res,
				pix_if.image_done, pix_if.overrun};
			if (decoded_runs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] pixel beat with none owed: color %h alpha %h repeat %0d done %b overrun %b",
						$time, got.color, got.alpha_value, got.repeat_res,
						got.image_done, got.overrun);
			end else begin
				want = decoded_runs.pop_front();
				if (got.color !== want.color || got.alpha_value !== want.alpha_value
						|| got.repeat_res !== want.repeat_res
						|| got.image_done !== want.image_done
						|| got.overrun !== want.overrun) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("[%0t] pixel beat %0d: expected color %h alpha %h repeat %0d done %b overrun %b, got color %h alpha %h repeat %0d done %b overrun %b",
							$time, beats_checked, want.color, want.alpha_value,
							want.repeat_res, want.image_done, want.overrun,
							got.color, got.alpha_value, got.repeat_res,
							got.image_done, got.overrun);
				end
				if (want.image_done)
					images_seen++;
				if (want.overrun)
					overruns_seen++;
			end
			beats_checked++;
		end

		if (byte_taken) begin
			decode_byte(byte_if.stream_byte);
			bytes_taken++;
		end

		if (beat_taken || byte_taken)
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] no beat for %0d cycles", $time, quiet_cycles);
			$display("tga_rle_pixel_decoder: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		logic [COUNT_W-1:0] new_count;
		int unsigned        pixels;
		int unsigned        target;
		bit                 first_setting;

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		byte_if.valid       = 1'b0;
		byte_if.stream_byte = '0;
		pix_if.ready        = 1'b0;
		in_idling           = 1'b0;
		out_idling          = 1'b0;

		// Register defaults after reset.
		cfg_bpp   = 2'd3;
		cfg_alpha = 1'b0;
		cfg_count = COUNT_W'(1);
		restart_image();

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, starting from the reset settings: three colour
		// bytes, no alpha, a one-pixel image.
		in_idling  = 1'b1;
		out_idling = 1'b1;
		// A one-pixel literal packet with extreme colour bytes ends the image.
		push_coded(8'h00); push_coded(8'hFF); push_coded(8'h00); push_coded(8'hAA);
		// A run of six on a one-pixel image is cut short and flagged.
		push_coded(8'h85); push_coded(8'h01); push_coded(8'h02); push_coded(8'h03);
		wait_drained(DRAIN_CYCLES);
		settings_run++;

		// Zero width and zero count both fall back to one, now with alpha.
		apb_write(REG_BPP, 32'd0);
		apb_write(REG_ALPHA, 32'd1);
		apb_write(REG_COUNT, 32'd0);
		in_idling  = 1'b0;
		out_idling = 1'b0;
		// The longest literal packet overruns at once; its next byte is
		// then taken as a new header for a single repeated pixel.
		push_coded(8'h7F); push_coded(8'h00); push_coded(8'hFF);
		push_coded(8'h80); push_coded(8'h55); push_coded(8'hAA);
		wait_drained(DRAIN_CYCLES);
		settings_run++;

		// An image of 32'hFFFE_0001 pixels, two colour bytes plus alpha.
		apb_write(REG_BPP, 32'd2);
		apb_write(REG_COUNT, 32'hFFFE_0001);
		// Longest repeat run, a two-pixel literal packet, then a pixel left
		// half read.
		push_coded(8'hFF); push_coded(8'h12); push_coded(8'h34); push_coded(8'h56);
		push_coded(8'h01);
		push_coded(8'hAB); push_coded(8'hCD); push_coded(8'hEF);
		push_coded(8'h01); push_coded(8'h23); push_coded(8'h45);
		push_coded(8'h00); push_coded(8'h77);
		wait_drained(DRAIN_CYCLES);
		settings_run++;

		// Narrowing the pixel mid-way: the next byte completes it as alpha.
		apb_write(REG_BPP, 32'd1);
		push_coded(8'h99);
		wait_drained(DRAIN_CYCLES);
		settings_run++;

		// Random part. Each setting may rewrite any register (the first one all
		// three), picks how the two channels idle, and sends mostly well-formed
		// images, with the odd burst of raw noise or a packet broken off part
		// way. Leaving the count alone keeps any half-read pixel across the change.
		target        = bytes_queued + RANDOM_BYTES;
		first_setting = 1'b1;
		while (bytes_queued < target) begin
			if (first_setting || $urandom_range(0, 3) != 0)
				apb_write(REG_BPP, APB_W'($urandom_range(0, 3)));
			if (first_setting || $urandom_range(0, 3) != 0)
				apb_write(REG_ALPHA, APB_W'($urandom_range(0, 1)));
			if (first_setting || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: new_count = '0;
					1: new_count = COUNT_W'(1);
					2: new_count = 32'hFFFE_0001;
					3: new_count = $urandom_range(2, 32'hFFFE_0001);
					default: new_count = $urandom_range(2, 48);
				endcase
				apb_write(REG_COUNT, new_count);
			end
			first_setting = 1'b0;
			in_idling     = ($urandom_range(0, 2) != 0);
			out_idling    = ($urandom_range(0, 2) != 0);

			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(5, 40)) push_coded(BYTE_W'($urandom));
			end else begin
				// Huge images never finish here; the byte budget bounds them.
				pixels = (cfg_count == '0) ? 1 : ((cfg_count > 64) ? 100000 : cfg_count);
				repeat ($urandom_range(1, 3))
					queue_image(pixels, $urandom_range(20, 160));
				if ($urandom_range(0, 3) == 0) begin
					push_coded(BYTE_W'($urandom));
					repeat ($urandom_range(0, ((cfg_bpp == '0) ? 1 : cfg_bpp) + cfg_alpha - 1))
						push_coded(pick_byte());
				end
			end
			wait_drained(DRAIN_CYCLES);
			settings_run++;
		end

		wait_drained(END_CYCLES);
		$display("Sent %0d coded bytes under %0d register settings.",
			bytes_taken, settings_run);
		$display("Checked %0d pixel beats, %0d image ends and %0d overruns.",
			beats_checked, images_seen, overruns_seen);
		if (mismatches == 0 && decoded_runs.size() == 0) begin
			$display("tga_rle_pixel_decoder: match");
		end else begin
			$display("tga_rle_pixel_decoder: mismatch");
		end
		$finish;
	end

endmodule
